// ----- rtl/geb_pkg.sv -----
// Shared widths, constants, arctangent table and rotation record for the ENU basis block.
`timescale 1ns / 1ps

package geb_pkg;

  // Format settings
  localparam int ANGLE_FRAC_BITS = 16;
  localparam int OUTPUT_WIDTH    = 16;
  localparam int CORDIC_STAGES   = 16;

  // Port field widths
  localparam int LAT_W = 24;
  localparam int LON_W = 25;
  localparam int OUT_W = OUTPUT_WIDTH;

  // Angle magnitude and nanodegree conversion
  localparam int MAG_W  = 24;
  localparam int NANO_W = 30;
  localparam int PROD_W = MAG_W + NANO_W;
  localparam int ZN_W   = PROD_W - ANGLE_FRAC_BITS;
  localparam int Z_W    = ZN_W + 1;

  // CORDIC datapath: Q2.30 carried with headroom
  localparam int XY_FRAC = 30;
  localparam int XY_W    = 34;
  localparam logic signed [XY_W-1:0] GAIN_Q30 = XY_W'(652032874);

  // Arctangent table, nanodegrees
  localparam int ATAN_N     = 32;
  localparam int ATAN_IDX_W = $clog2(ATAN_N);
  localparam logic signed [Z_W-1:0] ATAN_NDEG [ATAN_N] = '{
    Z_W'(64'sd45000000000), Z_W'(64'sd26565051177),
    Z_W'(64'sd14036243468), Z_W'(64'sd7125016349),
    Z_W'(64'sd3576334375),  Z_W'(64'sd1789910608),
    Z_W'(64'sd895173710),   Z_W'(64'sd447614171),
    Z_W'(64'sd223810500),   Z_W'(64'sd111905677),
    Z_W'(64'sd55952892),    Z_W'(64'sd27976453),
    Z_W'(64'sd13988227),    Z_W'(64'sd6994114),
    Z_W'(64'sd3497057),     Z_W'(64'sd1748528),
    Z_W'(64'sd874264),      Z_W'(64'sd437132),
    Z_W'(64'sd218566),      Z_W'(64'sd109283),
    Z_W'(64'sd54642),       Z_W'(64'sd27321),
    Z_W'(64'sd13660),       Z_W'(64'sd6830),
    Z_W'(64'sd3415),        Z_W'(64'sd1708),
    Z_W'(64'sd854),         Z_W'(64'sd427),
    Z_W'(64'sd213),         Z_W'(64'sd107),
    Z_W'(64'sd53),          Z_W'(64'sd27)
  };

  // One angle in flight through the rotation chain
  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic                   sneg;  // negate sine at the end
    logic                   cneg;  // negate cosine at the end
  } geb_rot_t;

endpackage

// ----- rtl/geb_front.sv -----
// Input conditioning: clamp, magnitude, nanodegree conversion and quadrant fold.
`timescale 1ns / 1ps

module geb_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic signed [geb_pkg::LAT_W-1:0] latitude,
  input  logic signed [geb_pkg::LON_W-1:0] longitude,
  output logic                            valid,
  output geb_pkg::geb_rot_t               lat,
  output geb_pkg::geb_rot_t               lon
);
  import geb_pkg::*;

  localparam logic signed [LAT_W-1:0] LAT_HI = LAT_W'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic signed [LON_W-1:0] LON_HI = LON_W'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [MAG_W-1:0]  LAT_MAG_MAX = MAG_W'(90 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [MAG_W-1:0]  LON_MAG_MAX = MAG_W'(180 * (2 ** ANGLE_FRAC_BITS));
  localparam logic [NANO_W-1:0] NANO_C      = NANO_W'(1000000000);
  localparam logic [PROD_W-1:0] HALF_A      = PROD_W'(1) << (ANGLE_FRAC_BITS - 1);
  localparam logic [ZN_W-1:0]   NDEG_90     = ZN_W'(64'd90000000000);
  localparam logic [ZN_W-1:0]   NDEG_180    = ZN_W'(64'd180000000000);

  logic                    v1, v2, v3, v4;
  logic signed [LAT_W-1:0] lat_cl;
  logic signed [LON_W-1:0] lon_cl;
  logic [MAG_W-1:0]        lat_mag1, lon_mag1;
  logic                    lat_neg1, lon_neg1, lat_neg2, lon_neg2, lat_neg3, lon_neg3;
  logic                    lat_neg4, lon_neg4, lat_cneg4, lon_cneg4;
  logic [PROD_W-1:0]       lat_prod2, lon_prod2;
  logic [ZN_W-1:0]         lat_zn3, lon_zn3, lat_z4, lon_z4;

  // Clamp to the legal range
  always_comb begin
    if (latitude > LAT_HI) begin
      lat_cl = LAT_HI;
    end else if (latitude < -LAT_HI) begin
      lat_cl = -LAT_HI;
    end else begin
      lat_cl = latitude;
    end
    if (longitude > LON_HI) begin
      lon_cl = LON_HI;
    end else if (longitude < -LON_HI) begin
      lon_cl = -LON_HI;
    end else begin
      lon_cl = longitude;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Payload: magnitude, scale to nanodegrees, round, fold above 90 degrees
  always_ff @(posedge clk) begin
    if (en) begin
      lat_neg1  <= lat_cl[LAT_W-1];
      lon_neg1  <= lon_cl[LON_W-1];
      lat_mag1  <= MAG_W'(lat_cl[LAT_W-1] ? -lat_cl : lat_cl);
      lon_mag1  <= MAG_W'(lon_cl[LON_W-1] ? -lon_cl : lon_cl);

      lat_neg2  <= lat_neg1;
      lon_neg2  <= lon_neg1;
      lat_prod2 <= PROD_W'(lat_mag1) * PROD_W'(NANO_C);
      lon_prod2 <= PROD_W'(lon_mag1) * PROD_W'(NANO_C);

      lat_neg3  <= lat_neg2;
      lon_neg3  <= lon_neg2;
      lat_zn3   <= ZN_W'((lat_prod2 + HALF_A) >> ANGLE_FRAC_BITS);
      lon_zn3   <= ZN_W'((lon_prod2 + HALF_A) >> ANGLE_FRAC_BITS);

      lat_neg4  <= lat_neg3;
      lon_neg4  <= lon_neg3;
      lat_cneg4 <= lat_zn3 > NDEG_90;
      lon_cneg4 <= lon_zn3 > NDEG_90;
      lat_z4    <= (lat_zn3 > NDEG_90) ? NDEG_180 - lat_zn3 : lat_zn3;
      lon_z4    <= (lon_zn3 > NDEG_90) ? NDEG_180 - lon_zn3 : lon_zn3;
    end
  end

  // Seed the rotation chain
  assign valid    = v4;
  assign lat.x    = GAIN_Q30;
  assign lat.y    = '0;
  assign lat.z    = signed'({1'b0, lat_z4});
  assign lat.sneg = lat_neg4;
  assign lat.cneg = lat_cneg4;
  assign lon.x    = GAIN_Q30;
  assign lon.y    = '0;
  assign lon.z    = signed'({1'b0, lon_z4});
  assign lon.sneg = lon_neg4;
  assign lon.cneg = lon_cneg4;

  // Clamp keeps magnitudes in range
  a_clamp: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (lat_mag1 <= LAT_MAG_MAX && lon_mag1 <= LON_MAG_MAX))
    else $error("geb_front: clamped magnitude out of range");

  // Fold leaves the angle in the first quadrant
  a_fold: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (lat_z4 <= NDEG_90 && lon_z4 <= NDEG_90))
    else $error("geb_front: folded angle above 90 degrees");

endmodule

// ----- rtl/geb_cordic_cell.sv -----
// One CORDIC micro-rotation for the latitude and longitude angles, registered.
`timescale 1ns / 1ps

module geb_cordic_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic [geb_pkg::ATAN_IDX_W-1:0]      stage,
  input  logic                                prev_valid,
  input  geb_pkg::geb_rot_t                   prev_lat,
  input  geb_pkg::geb_rot_t                   prev_lon,
  output logic                                valid,
  output geb_pkg::geb_rot_t                   lat,
  output geb_pkg::geb_rot_t                   lon
);
  import geb_pkg::*;

  // Rotate toward zero residual angle by atan(2^-stage)
  function automatic geb_rot_t rotate(input geb_rot_t r, input logic [ATAN_IDX_W-1:0] i);
    geb_rot_t               o;
    logic signed [XY_W-1:0] dx;
    logic signed [XY_W-1:0] dy;
    o  = r;
    dx = r.y >>> i;
    dy = r.x >>> i;
    if (!r.z[Z_W-1]) begin
      o.x = r.x - dx;
      o.y = r.y + dy;
      o.z = r.z - ATAN_NDEG[i];
    end else begin
      o.x = r.x + dx;
      o.y = r.y - dy;
      o.z = r.z + ATAN_NDEG[i];
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lat <= rotate(prev_lat, stage);
      lon <= rotate(prev_lon, stage);
    end
  end

  // Valid moves one cell per advance
  a_step: assert property (@(posedge clk) disable iff (rst)
    en |=> (valid == $past(prev_valid)))
    else $error("geb_cordic_cell: valid lost or duplicated");

endmodule

// ----- rtl/geb_back.sv -----
// Sign restore, basis products and rounding to the saturated Q1.15 outputs.
`timescale 1ns / 1ps

module geb_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              prev_valid,
  input  geb_pkg::geb_rot_t                 prev_lat,
  input  geb_pkg::geb_rot_t                 prev_lon,
  output logic                              valid,
  output logic signed [geb_pkg::OUT_W-1:0]  up_x,
  output logic signed [geb_pkg::OUT_W-1:0]  up_y,
  output logic signed [geb_pkg::OUT_W-1:0]  up_z,
  output logic signed [geb_pkg::OUT_W-1:0]  east_x,
  output logic signed [geb_pkg::OUT_W-1:0]  east_y,
  output logic signed [geb_pkg::OUT_W-1:0]  north_x,
  output logic signed [geb_pkg::OUT_W-1:0]  north_y,
  output logic signed [geb_pkg::OUT_W-1:0]  north_z
);
  import geb_pkg::*;

  localparam int PW   = 2 * XY_W;
  localparam int WK   = XY_W + 2;
  localparam int SH_P = 2 * XY_FRAC - (OUT_W - 1);
  localparam int SH_1 = XY_FRAC - (OUT_W - 1);
  localparam int SH_1R = (SH_1 > 0) ? SH_1 : 0;
  localparam int SH_1L = (SH_1 > 0) ? 0 : -SH_1;
  localparam int SH_1H = (SH_1 > 0) ? SH_1 - 1 : 0;
  localparam logic signed [PW-1:0] HALF_P = PW'(1) <<< (SH_P - 1);
  localparam logic signed [PW-1:0] HI_P   = (PW'(1) <<< (OUT_W - 1)) - PW'(1);
  localparam logic signed [PW-1:0] LO_P   = -HI_P - PW'(1);
  localparam logic signed [WK-1:0] HALF_1 = (SH_1 > 0) ? (WK'(1) <<< SH_1H) : WK'(0);
  localparam logic signed [WK-1:0] HI_1   = (WK'(1) <<< (OUT_W - 1)) - WK'(1);
  localparam logic signed [WK-1:0] LO_1   = -HI_1 - WK'(1);

  // Q4.60 product to output, half up then saturate
  function automatic logic signed [OUT_W-1:0] rnd_prod(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] t;
    t = (v + HALF_P) >>> SH_P;
    if (t > HI_P) begin
      return OUT_W'(HI_P);
    end else if (t < LO_P) begin
      return OUT_W'(LO_P);
    end
    return OUT_W'(t);
  endfunction

  // Q2.30 term to output, half up then saturate
  function automatic logic signed [OUT_W-1:0] rnd_one(input logic signed [XY_W-1:0] v);
    logic signed [WK-1:0] t;
    t = ((WK'(v) + HALF_1) >>> SH_1R) <<< SH_1L;
    if (t > HI_1) begin
      return OUT_W'(HI_1);
    end else if (t < LO_1) begin
      return OUT_W'(LO_1);
    end
    return OUT_W'(t);
  endfunction

  logic                   v1, v2;
  logic signed [XY_W-1:0] sla1, nsla1, cla1, nslo1, slo1, clo1;
  logic signed [XY_W-1:0] sla2, nslo2, clo2, cla2;
  logic signed [PW-1:0]   p_cc2, p_cs2, p_nc2, p_ns2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      v1    <= prev_valid;
      v2    <= v1;
      valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // Restore signs
      sla1  <= prev_lat.sneg ? -prev_lat.y : prev_lat.y;
      nsla1 <= prev_lat.sneg ? prev_lat.y : -prev_lat.y;
      cla1  <= prev_lat.cneg ? -prev_lat.x : prev_lat.x;
      slo1  <= prev_lon.sneg ? -prev_lon.y : prev_lon.y;
      nslo1 <= prev_lon.sneg ? prev_lon.y : -prev_lon.y;
      clo1  <= prev_lon.cneg ? -prev_lon.x : prev_lon.x;

      // Products for up and north
      p_cc2 <= PW'(cla1) * PW'(clo1);
      p_cs2 <= PW'(cla1) * PW'(slo1);
      p_nc2 <= PW'(nsla1) * PW'(clo1);
      p_ns2 <= PW'(nsla1) * PW'(slo1);
      sla2  <= sla1;
      nslo2 <= nslo1;
      clo2  <= clo1;
      cla2  <= cla1;

      // Output register
      up_x    <= rnd_prod(p_cc2);
      up_y    <= rnd_prod(p_cs2);
      up_z    <= rnd_one(sla2);
      east_x  <= rnd_one(nslo2);
      east_y  <= rnd_one(clo2);
      north_x <= rnd_prod(p_nc2);
      north_y <= rnd_prod(p_ns2);
      north_z <= rnd_one(cla2);
    end
  end

endmodule

// ----- rtl/geodetic_enu_basis_core.sv -----
// Top level: geodetic position in, local east/north/up unit vectors out.
`timescale 1ns / 1ps

// Accepts one latitude/longitude pair per clock while pos_stall is low and returns one
// set of ENU basis vectors per pair, in order, after 4 conditioning stages, 16 rotation
// cells (CORDIC_STAGES) and 3 product and rounding stages. The rate is set by the row of
// CORDIC cells, each doing one micro-rotation for both angles per cycle. A stall on the
// result channel while a result is valid freezes the whole pipeline and is passed back
// as pos_stall; there is no other stall. Angles outside plus or minus 90 (latitude) and
// 180 (longitude) degrees are clamped. All components are Q1.15, saturating at -32768/+32767.
module geodetic_enu_basis_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              pos_valid,
  output logic                              pos_stall,
  input  logic signed [geb_pkg::LAT_W-1:0]  latitude,
  input  logic signed [geb_pkg::LON_W-1:0]  longitude,
  output logic                              basis_valid,
  input  logic                              basis_stall,
  output logic signed [geb_pkg::OUT_W-1:0]  up_x,
  output logic signed [geb_pkg::OUT_W-1:0]  up_y,
  output logic signed [geb_pkg::OUT_W-1:0]  up_z,
  output logic signed [geb_pkg::OUT_W-1:0]  east_x,
  output logic signed [geb_pkg::OUT_W-1:0]  east_y,
  output logic signed [geb_pkg::OUT_W-1:0]  north_x,
  output logic signed [geb_pkg::OUT_W-1:0]  north_y,
  output logic signed [geb_pkg::OUT_W-1:0]  north_z
);
  import geb_pkg::*;

  logic     adv;
  logic     vld_c [CORDIC_STAGES+1];
  geb_rot_t lat_c [CORDIC_STAGES+1];
  geb_rot_t lon_c [CORDIC_STAGES+1];

  // Pipeline moves unless a finished result is held back
  assign adv       = !(basis_valid && basis_stall);
  assign pos_stall = !adv;

  geb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (pos_valid),
    .latitude  (latitude),
    .longitude (longitude),
    .valid     (vld_c[0]),
    .lat       (lat_c[0]),
    .lon       (lon_c[0])
  );

  // Row of rotation cells
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    geb_cordic_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .en         (adv),
      .stage      (ATAN_IDX_W'(i)),
      .prev_valid (vld_c[i]),
      .prev_lat   (lat_c[i]),
      .prev_lon   (lon_c[i]),
      .valid      (vld_c[i+1]),
      .lat        (lat_c[i+1]),
      .lon        (lon_c[i+1])
    );
  end

  geb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .en         (adv),
    .prev_valid (vld_c[CORDIC_STAGES]),
    .prev_lat   (lat_c[CORDIC_STAGES]),
    .prev_lon   (lon_c[CORDIC_STAGES]),
    .valid      (basis_valid),
    .up_x       (up_x),
    .up_y       (up_y),
    .up_z       (up_z),
    .east_x     (east_x),
    .east_y     (east_y),
    .north_x    (north_x),
    .north_y    (north_y),
    .north_z    (north_z)
  );

endmodule
